// File: hdl/uepu_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// uepu_pkg
// Shared types, constants and helpers for the unicode escape unescaper.
// ============================================================================
package uepu_pkg;

    localparam int HEX_DIGITS  = 4;
    localparam int STORE_DEPTH = HEX_DIGITS - 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int DIGIT_W     = 7;
    localparam int UNIT_W      = 16;

    localparam logic [UNIT_W-1:0] CH_BACKSLASH = 16'h005C;
    localparam logic [UNIT_W-1:0] CH_U         = 16'h0075;
    localparam logic [UNIT_W-1:0] CH_X         = 16'h0078;
    localparam logic [UNIT_W-1:0] CH_ZERO      = 16'h0030;
    localparam logic [UNIT_W-1:0] CH_NUL       = 16'h0000;

    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              is_final;
    } in_beat_t;

    typedef struct packed {
        logic [UNIT_W-1:0] out_unit;
        logic              has_unit;
        logic              end_of_pattern;
    } out_beat_t;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_ESCAPE = 3'b010,
        MODE_HEX    = 3'b100
    } mode_t;

    typedef enum logic [1:0] {
        MAIN_NONE = 2'd0,
        MAIN_UNIT = 2'd1,
        MAIN_BS   = 2'd2,
        MAIN_NUL  = 2'd3
    } main_kind_t;

    typedef logic [STORE_DEPTH-1:0][DIGIT_W-1:0] digit_arr_t;

    // One classified input: optional flush of a broken sequence, then the main part.
    typedef struct packed {
        logic              flush;
        logic [1:0]        digit_n;
        digit_arr_t        digits;
        main_kind_t        kind;
        logic [UNIT_W-1:0] unit;
        logic              fin;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

    function automatic logic [4:0] hex_digit(input logic [UNIT_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 16'h0030 && c <= 16'h0039) begin
            r = {1'b1, 4'(c - 16'h0030)};
        end else if (c >= 16'h0061 && c <= 16'h0066) begin
            r = {1'b1, 4'(c - 16'h0057)};
        end else if (c >= 16'h0041 && c <= 16'h0046) begin
            r = {1'b1, 4'(c - 16'h0037)};
        end
        return r;
    endfunction

    function automatic logic is_meta(input logic [UNIT_W-1:0] u);
        logic r;
        case (u) inside
            16'h005E, 16'h0024, 16'h005C, 16'h002E, 16'h002A, 16'h002B, 16'h003F,
            16'h0028, 16'h0029, 16'h007B, 16'h007D, 16'h005B, 16'h005D, 16'h007C:
                r = 1'b1;
            default:
                r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/unicode_escape_pattern_unescaper.sv
`timescale 1ns / 1ps
// ============================================================================
// unicode_escape_pattern_unescaper
// Rewrites a pattern stream, decoding backslash-u hex escapes.
// ============================================================================
// The block takes one code unit per cycle and writes one output unit per
// cycle while the queue has room and the output is not stalled. An input
// that expands into several units holds the output port for one beat per
// unit, since the back end emits a single beat per cycle from each queued
// command. The front end classifies each input as it is accepted and
// queues any command in a QUEUE_DEPTH-entry queue, so input keeps flowing
// while expansions drain; the back end registers each output beat.
module unicode_escape_pattern_unescaper #(
    parameter int QUEUE_DEPTH = uepu_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  uepu_pkg::in_beat_t  in_beat,
    output logic                out_valid,
    input  logic                out_ready,
    output uepu_pkg::out_beat_t out_beat
);
    import uepu_pkg::*;

    logic queue_full;
    logic push;
    logic pop;
    logic head_valid;
    cmd_t push_cmd;
    cmd_t head_cmd;

    uepu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_beat    (in_beat),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    uepu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    uepu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_beat   (out_beat)
    );

endmodule

// File: hdl/uepu_front.sv
`timescale 1ns / 1ps
// ============================================================================
// uepu_front
// Accepts code units, tracks escape parsing and emits a command for each input that yields output, a flush or the end.
// ============================================================================
module uepu_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  uepu_pkg::in_beat_t in_beat,
    input  logic              queue_full,
    output logic              push,
    output uepu_pkg::cmd_t    push_cmd
);
    import uepu_pkg::*;

    mode_t             mode_reg, mode_next;
    logic [1:0]        count_reg, count_next;
    logic [UNIT_W-1:0] hex_reg, hex_next;
    digit_arr_t        store_reg, store_next;

    logic [UNIT_W-1:0] c;
    logic [4:0]        hd;
    logic [UNIT_W-1:0] hv;
    logic              do_normal;
    logic              accept;
    cmd_t              cmd;

    assign c        = in_beat.code_unit;
    assign hd       = hex_digit(c);
    assign hv       = {hex_reg[UNIT_W-5:0], hd[3:0]};
    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        mode_next    = mode_reg;
        count_next   = count_reg;
        hex_next     = hex_reg;
        store_next   = store_reg;
        do_normal    = 1'b0;
        cmd.flush    = 1'b0;
        cmd.digit_n  = count_reg;
        cmd.digits   = store_reg;
        cmd.kind     = MAIN_NONE;
        cmd.unit     = c;
        cmd.fin      = in_beat.is_final;

        unique case (mode_reg)
            MODE_HEX:
            begin
                if (hd[4]) begin
                    if (count_reg == 2'(HEX_DIGITS - 1)) begin
                        mode_next  = MODE_NORMAL;
                        count_next = 2'd0;
                        hex_next   = '0;
                        cmd.unit   = hv;
                        if (hv == CH_NUL) begin
                            cmd.kind = MAIN_NUL;
                        end else if (is_meta(hv)) begin
                            cmd.kind = MAIN_BS;
                        end else begin
                            cmd.kind = MAIN_UNIT;
                        end
                    end else begin
                        store_next[count_reg] = c[DIGIT_W-1:0];
                        count_next            = count_reg + 2'd1;
                        hex_next              = hv;
                    end
                end else begin
                    cmd.flush  = 1'b1;
                    count_next = 2'd0;
                    hex_next   = '0;
                    do_normal  = 1'b1;
                end
            end
            MODE_ESCAPE:
            begin
                if (c == CH_U) begin
                    mode_next  = MODE_HEX;
                    count_next = 2'd0;
                    hex_next   = '0;
                end else begin
                    mode_next = MODE_NORMAL;
                    cmd.kind  = MAIN_BS;
                end
            end
            default:
            begin
                do_normal = 1'b1;
            end
        endcase

        if (do_normal) begin
            if (c == CH_BACKSLASH) begin
                mode_next = MODE_ESCAPE;
            end else begin
                mode_next = MODE_NORMAL;
                cmd.kind  = (c == CH_NUL) ? MAIN_NUL : MAIN_UNIT;
            end
        end

        if (in_beat.is_final) begin
            if (mode_next == MODE_HEX) begin
                cmd.flush   = 1'b1;
                cmd.digit_n = count_next;
                cmd.digits  = store_next;
            end
            mode_next  = MODE_NORMAL;
            count_next = 2'd0;
            hex_next   = '0;
        end
    end

    assign push     = accept && (cmd.fin || cmd.flush || cmd.kind != MAIN_NONE);
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_NORMAL;
            count_reg <= 2'd0;
            hex_reg   <= '0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            hex_reg   <= hex_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            store_reg <= store_next;
        end
    end

endmodule

// File: hdl/uepu_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// uepu_queue
// Short command queue between the front and back ends.
// ============================================================================
module uepu_queue #(
    parameter int DEPTH = uepu_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  uepu_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output uepu_pkg::cmd_t head_cmd
);
    import uepu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: hdl/uepu_back.sv
`timescale 1ns / 1ps
// ============================================================================
// uepu_back
// Expands each queued command into output beats, one per cycle unless stalled.
// ============================================================================
module uepu_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  uepu_pkg::cmd_t     head_cmd,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output uepu_pkg::out_beat_t out_beat
);
    import uepu_pkg::*;

    logic [2:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    out_beat_t   out_beat_reg, out_beat_next;

    logic [2:0]  flush_n;
    logic [2:0]  main_n;
    logic [3:0]  total;
    logic        empty;
    logic [2:0]  last_idx;
    logic [2:0]  j;
    logic [2:0]  d_idx;
    logic        load;
    logic        is_last;
    logic [UNIT_W-1:0] unit;

    assign flush_n  = head_cmd.flush ? 3'(head_cmd.digit_n) + 3'd1 : 3'd0;
    assign total    = 4'(flush_n) + 4'(main_n);
    assign empty    = (total == 4'd0);
    assign last_idx = empty ? 3'd0 : 3'(total - 4'd1);
    assign is_last  = (idx_reg == last_idx);
    assign j        = idx_reg - flush_n;
    assign d_idx    = idx_reg - 3'd1;
    assign load     = !out_valid_reg || out_ready;
    assign pop      = load && head_valid && is_last;

    always_comb
    begin
        case (head_cmd.kind)
            MAIN_UNIT: main_n = 3'd1;
            MAIN_BS:   main_n = 3'd2;
            MAIN_NUL:  main_n = 3'd4;
            default:   main_n = 3'd0;
        endcase
    end

    always_comb
    begin
        unit = head_cmd.unit;
        if (idx_reg < flush_n) begin
            if (idx_reg == 3'd0) begin
                unit = CH_U;
            end else begin
                unit = UNIT_W'(head_cmd.digits[d_idx[1:0]]);
            end
        end else begin
            case (head_cmd.kind)
                MAIN_BS:
                begin
                    unit = (j == 3'd0) ? CH_BACKSLASH : head_cmd.unit;
                end
                MAIN_NUL:
                begin
                    case (j[1:0])
                        2'd0:    unit = CH_BACKSLASH;
                        2'd1:    unit = CH_X;
                        default: unit = CH_ZERO;
                    endcase
                end
                default:
                begin
                    unit = head_cmd.unit;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_beat_next  = out_beat_reg;
        idx_next       = idx_reg;
        if (load) begin
            out_valid_next = head_valid;
            if (head_valid) begin
                out_beat_next.out_unit       = empty ? CH_NUL : unit;
                out_beat_next.has_unit       = !empty;
                out_beat_next.end_of_pattern = head_cmd.fin && is_last;
                idx_next                     = is_last ? 3'd0 : idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_beat_reg <= out_beat_next;
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

endmodule

// File: hdl/uepu_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// uepu_checker
// Port-level checks for the unicode escape unescaper.
// ============================================================================
module uepu_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input uepu_pkg::out_beat_t out_beat
);
    import uepu_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_beat))
        else $error("output beat changed while stalled");

    a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_beat.has_unit |->
            out_beat.end_of_pattern && out_beat.out_unit == CH_NUL)
        else $error("empty beat is not a clean end marker");

    a_rise_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("output appeared without an input beat");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output side is empty");

endmodule

bind unicode_escape_pattern_unescaper uepu_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
);
